@@ rtl/core/iss_pkg.sv @@
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types and constants for the set statistics block.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int MAX_ITEMS  = 256;
  localparam int VALUE_BITS = 32;
  localparam int SUM_W      = 40;
  localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
  localparam int STEP_W     = $clog2(SUM_W + 1);

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SCAN,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [CNT_W-1:0]             freq;
    logic signed [VALUE_BITS-1:0] val;
  } cand_t;

endpackage

@@ rtl/core/iss_cell.sv @@
// ----------------------------------------------------------------------------
// iss_cell
// One table slot: distinct value and its count, plus one stage of the
// mode search that runs down the chain.
// ----------------------------------------------------------------------------
module iss_cell (
  input  logic                            clk_i,
  input  logic [iss_pkg::CNT_W-1:0]       idx_i,
  input  logic [iss_pkg::CNT_W-1:0]       used_i,
  input  logic                            upd_i,
  input  logic signed [iss_pkg::VALUE_BITS-1:0] val_i,
  input  logic                            any_match_i,
  output logic                            match_o,
  input  iss_pkg::cand_t                  cand_i,
  output iss_pkg::cand_t                  cand_o
);
  import iss_pkg::*;

  logic signed [VALUE_BITS-1:0] val_q;
  logic [CNT_W-1:0]             freq_q;
  cand_t                        cand_q;
  logic                         occ;
  logic                         take;

  assign occ     = idx_i < used_i;
  assign match_o = occ && (val_q == val_i);
  assign take    = occ && ((freq_q > cand_i.freq) ||
                           ((freq_q == cand_i.freq) && (val_q < cand_i.val)));

  always_ff @(posedge clk_i) begin
    if (upd_i && match_o) begin
      freq_q <= freq_q + CNT_W'(1);
    end else if (upd_i && !any_match_i && (idx_i == used_i)) begin
      val_q  <= val_i;
      freq_q <= CNT_W'(1);
    end
    if (take) begin
      cand_q.freq <= freq_q;
      cand_q.val  <= val_q;
    end else begin
      cand_q <= cand_i;
    end
  end

  assign cand_o = cand_q;

endmodule

@@ rtl/core/iss_div.sv @@
// ----------------------------------------------------------------------------
// iss_div
// Bit-serial signed divide of the sum by the element count, one quotient
// bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
module iss_div (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  input  logic signed [iss_pkg::SUM_W-1:0]   num_i,
  input  logic [iss_pkg::CNT_W-1:0]          den_i,
  output logic                               done_o,
  output logic signed [iss_pkg::VALUE_BITS-1:0] quo_o
);
  import iss_pkg::*;

  logic [SUM_W-1:0]  quo_q, quo_d;
  logic [CNT_W:0]    rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              neg_q, neg_d;
  logic [CNT_W:0]    rem_sh;
  logic [SUM_W-1:0]  quo_fix;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = done_q;
    neg_d  = neg_q;
    rem_sh = {rem_q[CNT_W-1:0], quo_q[SUM_W-1]};
    if (start_i) begin
      neg_d  = num_i[SUM_W-1];
      quo_d  = num_i[SUM_W-1] ? (~num_i + SUM_W'(1)) : num_i;
      rem_d  = '0;
      step_d = '0;
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      if (rem_sh >= {1'b0, den_i}) begin
        rem_d = rem_sh - {1'b0, den_i};
        quo_d = {quo_q[SUM_W-2:0], 1'b1};
      end else begin
        rem_d = rem_sh;
        quo_d = {quo_q[SUM_W-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
  end

  assign quo_fix = neg_q ? (~quo_q + SUM_W'(1)) : quo_q;
  assign quo_o   = (den_i == '0) ? '0 : quo_fix[VALUE_BITS-1:0];
  assign done_o  = done_q;

endmodule

@@ rtl/core/integer_set_statistics.sv @@
// ----------------------------------------------------------------------------
// integer_set_statistics
// Sum, mean, mode and count of a set of signed integers.
// ----------------------------------------------------------------------------
// Elements load at one beat per cycle while the input is not stalled, into a
// row of MAX_ITEMS cells that match each value against all stored distinct
// values at once. On the beat marked last the input stalls while the mode
// search walks down the cell row, with the serial divide for the mean running
// alongside; the result then waits in the output stage until taken, after
// which the set is cleared and input opens again.
module integer_set_statistics (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [iss_pkg::VALUE_BITS-1:0] value_i,
  input  logic                                  has_value_i,
  input  logic                                  last_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [iss_pkg::SUM_W-1:0]      total_o,
  output logic signed [iss_pkg::VALUE_BITS-1:0] mean_o,
  output logic signed [iss_pkg::VALUE_BITS-1:0] mode_o,
  output logic [iss_pkg::CNT_W-1:0]             element_count_o,
  output logic                                  empty_set_o,
  output logic                                  overflowed_o
);
  import iss_pkg::*;

  state_e            state_q, state_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  scan_q, scan_d;
  logic              drop_q, drop_d;
  logic              in_acc, upd, any_match, div_start, div_done;
  logic [MAX_ITEMS-1:0] match;
  cand_t             chain [MAX_ITEMS+1];

  assign in_acc    = in_valid_i && !in_stall_o;
  assign upd       = in_acc && has_value_i && (cnt_q < CNT_W'(MAX_ITEMS));
  assign any_match = |match;
  assign chain[0]  = '0;
  assign div_start = (state_q == ST_SCAN) && (scan_q == '0);

  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    iss_cell u_cell (
      .clk_i       (clk_i),
      .idx_i       (CNT_W'(k)),
      .used_i      (used_q),
      .upd_i       (upd),
      .val_i       (value_i),
      .any_match_i (any_match),
      .match_o     (match[k]),
      .cand_i      (chain[k]),
      .cand_o      (chain[k+1])
    );
  end

  iss_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (sum_q),
    .den_i   (cnt_q),
    .done_o  (div_done),
    .quo_o   (mean_o)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD: if (in_acc && last_i) state_d = ST_SCAN;
      ST_SCAN: if ((scan_q == CNT_W'(MAX_ITEMS - 1)) && div_done) state_d = ST_OUT;
      ST_OUT:  if (!out_stall_i) state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    sum_d  = sum_q;
    cnt_d  = cnt_q;
    used_d = used_q;
    drop_d = drop_q;
    scan_d = scan_q;
    if (in_acc && has_value_i) begin
      if (upd) begin
        sum_d = sum_q + SUM_W'(value_i);
        cnt_d = cnt_q + CNT_W'(1);
        if (!any_match) used_d = used_q + CNT_W'(1);
      end else begin
        drop_d = 1'b1;
      end
    end
    if (state_q == ST_LOAD) begin
      scan_d = '0;
    end else if (state_q == ST_SCAN && scan_q != CNT_W'(MAX_ITEMS - 1)) begin
      scan_d = scan_q + CNT_W'(1);
    end
    if (state_q == ST_OUT && !out_stall_i) begin
      sum_d  = '0;
      cnt_d  = '0;
      used_d = '0;
      drop_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      sum_q   <= '0;
      cnt_q   <= '0;
      used_q  <= '0;
      drop_q  <= 1'b0;
      scan_q  <= '0;
    end else begin
      state_q <= state_d;
      sum_q   <= sum_d;
      cnt_q   <= cnt_d;
      used_q  <= used_d;
      drop_q  <= drop_d;
      scan_q  <= scan_d;
    end
  end

  assign in_stall_o      = state_q != ST_LOAD;
  assign out_valid_o     = state_q == ST_OUT;
  assign total_o         = sum_q;
  assign mode_o          = chain[MAX_ITEMS].val;
  assign element_count_o = cnt_q;
  assign empty_set_o     = cnt_q == '0;
  assign overflowed_o    = drop_q;

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the set statistics block.
// ----------------------------------------------------------------------------
// Sets of signed values are sent as beats. A local model keeps the running
// sum, the count and the value histogram, and works out the sum, mean, mode,
// count and flags for each closing beat. Every result is checked field by
// field against the oldest pending prediction. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_top;
  import iss_pkg::*;

  typedef struct {
    logic signed [SUM_W-1:0]      total;
    logic signed [VALUE_BITS-1:0] mean;
    logic signed [VALUE_BITS-1:0] mode;
    logic [CNT_W-1:0]             cnt;
    logic                         empty;
    logic                         ovf;
  } stats_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic signed [VALUE_BITS-1:0] value_i = '0;
  logic has_value_i = 1'b0;
  logic last_i = 1'b0;
  logic out_stall_i = 1'b0;
  logic in_stall_o, out_valid_o, empty_set_o, overflowed_o;
  logic signed [SUM_W-1:0] total_o;
  logic signed [VALUE_BITS-1:0] mean_o, mode_o;
  logic [CNT_W-1:0] element_count_o;

  stats_t stats_q[$];
  int errors = 0;
  int burst_left = 0;
  bit stall_on = 1'b1;

  logic signed [SUM_W-1:0] set_sum;
  int set_cnt;
  bit set_drop;
  int hist_n;
  logic signed [VALUE_BITS-1:0] hist_val[MAX_ITEMS];
  int hist_freq[MAX_ITEMS];

  integer_set_statistics dut (.*);

  initial forever #6 clk_i = ~clk_i;

  task automatic clear_set();
    set_sum = '0;
    set_cnt = 0;
    set_drop = 1'b0;
    hist_n = 0;
  endtask

  task automatic model_beat(logic signed [VALUE_BITS-1:0] v, bit hv, bit lst);
    stats_t r;
    bit hit;
    int best;
    longint s;
    hit = 1'b0;
    if (hv) begin
      if (set_cnt >= MAX_ITEMS) begin
        set_drop = 1'b1;
      end else begin
        set_sum = set_sum + SUM_W'(v);
        set_cnt++;
        for (int i = 0; i < hist_n; i++) begin
          if (!hit && hist_val[i] == v) begin
            hist_freq[i]++;
            hit = 1'b1;
          end
        end
        if (!hit) begin
          hist_val[hist_n] = v;
          hist_freq[hist_n] = 1;
          hist_n++;
        end
      end
    end
    if (lst) begin
      r.total = set_sum;
      r.cnt = CNT_W'(set_cnt);
      r.empty = (set_cnt == 0);
      r.ovf = set_drop;
      r.mean = '0;
      r.mode = '0;
      if (set_cnt != 0) begin
        s = longint'(set_sum);
        r.mean = VALUE_BITS'(s / longint'(set_cnt));
        best = 0;
        for (int i = 0; i < hist_n; i++) begin
          if (hist_freq[i] > best || (hist_freq[i] == best && hist_val[i] < r.mode)) begin
            best = hist_freq[i];
            r.mode = hist_val[i];
          end
        end
      end
      stats_q.insert(stats_q.size(), r);
      clear_set();
    end
  endtask

  task automatic report(string what, longint got, longint exp);
    $display("mismatch %s: got %0d expected %0d", what, got, exp);
    errors++;
  endtask

  // sender: bursts with random gaps
  task automatic send_beat(logic signed [VALUE_BITS-1:0] v, bit hv, bit lst);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    value_i <= v;
    has_value_i <= hv;
    last_i <= lst;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_beat(v, hv, lst);
    @(negedge clk_i);
  endtask

  function automatic logic signed [VALUE_BITS-1:0] rand_val(int mode_sel);
    case (mode_sel)
      0: return $urandom_range(0, 5) - 2;
      1: return $urandom();
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom_range(0, 40) - 20;
    endcase
  endfunction

  task automatic send_set(int n, int vmode, bit lst_val);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) send_beat($urandom(), 1'b0, 1'b0);
      send_beat(rand_val(vmode), 1'b1, 1'b0);
    end
    if (lst_val) send_beat(rand_val(vmode), 1'b1, 1'b1);
    else send_beat($urandom(), 1'b0, 1'b1);
  endtask

  task automatic test_directed();
    send_beat(0, 1'b0, 1'b1);
    send_beat(32'sh7fffffff, 1'b1, 1'b1);
    send_beat(32'sh80000000, 1'b1, 1'b1);
    send_beat(-7, 1'b1, 1'b0);
    send_beat(32'shffffffff, 1'b0, 1'b0);
    send_beat(2, 1'b1, 1'b0);
    send_beat(0, 1'b0, 1'b1);
    send_beat(5, 1'b1, 1'b0);
    send_beat(-3, 1'b1, 1'b0);
    send_beat(5, 1'b1, 1'b0);
    send_beat(-3, 1'b1, 1'b1);
    send_beat(32'sh80000000, 1'b1, 1'b0);
    send_beat(32'sh80000000, 1'b1, 1'b0);
    send_beat(32'sh7fffffff, 1'b1, 1'b1);
  endtask

  // fills every table slot with a distinct value, then overruns the count
  task automatic test_capacity();
    for (int i = 0; i < MAX_ITEMS + 2; i++) begin
      send_beat(32'sh7fffffff - i, 1'b1, 1'b0);
    end
    send_beat(32'sh80000000, 1'b1, 1'b1);
  endtask

  task automatic test_random();
    for (int k = 0; k < 45; k++) begin
      send_set($urandom_range(0, 12), $urandom_range(0, 3), 1'($urandom_range(0, 1)));
    end
  endtask

  // receiver stall pattern, with calm stretches
  always @(negedge clk_i) begin
    if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
    out_stall_i <= stall_on ? ($urandom_range(0, 2) == 0) : 1'b0;
  end

  always @(posedge clk_i) begin
    stats_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (stats_q.size() == 0) begin
        report("unexpected result", 0, 0);
      end else begin
        e = stats_q.pop_front();
        if (total_o !== e.total) report("total", total_o, e.total);
        if (mean_o !== e.mean) report("mean", mean_o, e.mean);
        if (mode_o !== e.mode) report("mode", mode_o, e.mode);
        if (element_count_o !== e.cnt) report("element_count", element_count_o, e.cnt);
        if (empty_set_o !== e.empty) report("empty_set", empty_set_o, e.empty);
        if (overflowed_o !== e.ovf) report("overflowed", overflowed_o, e.ovf);
      end
    end
  end

  initial begin
    clear_set();
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_capacity();
    test_random();
    in_valid_i <= 1'b0;
    while (stats_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0 && stats_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("tb_top: errors");
    $finish;
  end
endmodule

@@ files.f @@
rtl/core/iss_pkg.sv
rtl/core/iss_cell.sv
rtl/core/iss_div.sv
rtl/core/integer_set_statistics.sv
tb/sv/tb_top.sv
